// ===== design/bpa_pkg.sv =====
// shared types, constants and codes for the block pool allocator
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MAX_POOLS_DEF  = 8;
    localparam int MAX_BLOCKS_DEF = 128;

    localparam int OP_W       = 2;
    localparam int REQ_W      = 16;
    localparam int SLOT_W     = 3;
    localparam int BLK_W      = 7;
    localparam int STATUS_W   = 3;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIZE_W-1:0]  SIZE_FALLBACK  = 16'd1024;
    localparam logic [COUNT_W-1:0] COUNT_FALLBACK = 8'd100;
    localparam int                 COUNT_CAP      = 128;
    localparam int                 CHUNK_W        = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXISTING = 3'd0,
        ST_NEW      = 3'd1,
        ST_NO_SLOT  = 3'd2,
        ST_FREED    = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_RESET    = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_SIZE  = 2'd0,
        REG_DEFAULT_COUNT = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_DEC,
        PTR_ZERO,
        PTR_INC,
        PTR_OPEN
    } ptr_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_LOAD,
        S_SEARCH,
        S_GRANT,
        S_OPEN,
        S_OPEN_WR,
        S_FREE_CHK,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     capture;
        ptr_cmd_t ptr_op;
        logic     ram_rd;
        logic     load_word;
        logic     shift_word;
        logic     search_hit;
        logic     grant_wr;
        logic     open_wr;
        logic     free_wr;
        logic     sweep_wr;
        logic     load_result;
        status_t  result;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pools_empty;
        logic            pools_full;
        logic            scan_hit;
        logic            ptr_zero;
        logic            chunk_hit;
        logic            free_ok;
        logic            sweep_last;
    } sts_t;

endpackage

// ===== design/bpa_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bpa_ctrl.sv =====
// controller state machine of the block pool allocator
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_stall,
    input  bpa_pkg::sts_t sts,
    output logic          in_stall,
    output logic          out_valid,
    output bpa_pkg::cmd_t cmd
);

    import bpa_pkg::*;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;
    logic    done_go;

    assign done_go = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_reg       <= ST_EXISTING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        state_next = sts.pools_empty ? S_OPEN : S_SCAN;
                    end
                    OP_FREE:
                    begin
                        state_next = S_FREE_CHK;
                    end
                    OP_CLEAR:
                    begin
                        if (sts.pools_empty)
                        begin
                            state_next = S_DONE;
                            res_next   = ST_RESET;
                        end
                        else
                        begin
                            state_next = S_SWEEP;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                        res_next   = ST_IGNORED;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    state_next = S_LOAD;
                end
                else if (sts.ptr_zero)
                begin
                    state_next = S_OPEN;
                end
            end
            S_LOAD:
            begin
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (sts.chunk_hit)
                begin
                    state_next = S_GRANT;
                end
            end
            S_GRANT:
            begin
                state_next = S_DONE;
                res_next   = ST_EXISTING;
            end
            S_OPEN:
            begin
                if (sts.pools_full)
                begin
                    state_next = S_DONE;
                    res_next   = ST_NO_SLOT;
                end
                else
                begin
                    state_next = S_OPEN_WR;
                end
            end
            S_OPEN_WR:
            begin
                state_next = S_DONE;
                res_next   = ST_NEW;
            end
            S_FREE_CHK:
            begin
                state_next = S_DONE;
                res_next   = sts.free_ok ? ST_FREED : ST_IGNORED;
            end
            S_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next = S_DONE;
                    res_next   = ST_RESET;
                end
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        if (!sts.pools_empty)
                        begin
                            cmd.ptr_op = PTR_TOP;
                        end
                    end
                    OP_FREE:
                    begin
                        cmd.ram_rd = 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        cmd.ptr_op = PTR_ZERO;
                    end
                    default:
                    begin
                        cmd.ptr_op = PTR_HOLD;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.ram_rd = 1'b1;
                end
                else if (!sts.ptr_zero)
                begin
                    cmd.ptr_op = PTR_DEC;
                end
            end
            S_LOAD:
            begin
                cmd.load_word = 1'b1;
            end
            S_SEARCH:
            begin
                cmd.search_hit = sts.chunk_hit;
                cmd.shift_word = !sts.chunk_hit;
            end
            S_GRANT:
            begin
                cmd.grant_wr = 1'b1;
            end
            S_OPEN:
            begin
                if (!sts.pools_full)
                begin
                    cmd.ptr_op = PTR_OPEN;
                end
            end
            S_OPEN_WR:
            begin
                cmd.open_wr = 1'b1;
            end
            S_FREE_CHK:
            begin
                cmd.free_wr = sts.free_ok;
            end
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (!sts.sweep_last)
                begin
                    cmd.ptr_op = PTR_INC;
                end
            end
            S_DONE:
            begin
                cmd.load_result = done_go;
                cmd.result      = res_reg;
            end
            default:
            begin
                cmd.ptr_op = PTR_HOLD;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/bpa_dpath.sv =====
// datapath of the block pool allocator: pool tables, bitmap ram, bit search, result register
`timescale 1ns / 1ps

module bpa_dpath #(
    parameter int MAX_POOLS  = bpa_pkg::MAX_POOLS_DEF,
    parameter int MAX_BLOCKS = bpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [bpa_pkg::OP_W-1:0]            op,
    input  logic [bpa_pkg::REQ_W-1:0]           request_size,
    input  logic [bpa_pkg::SLOT_W-1:0]          pool_slot,
    input  logic [bpa_pkg::BLK_W-1:0]           free_block,
    input  bpa_pkg::cmd_t                       cmd,
    output bpa_pkg::sts_t                       sts,
    output logic [bpa_pkg::STATUS_W-1:0]        status,
    output logic [bpa_pkg::SLOT_W-1:0]          granted_pool,
    output logic [bpa_pkg::BLK_W-1:0]           granted_block,
    output logic [bpa_pkg::SIZE_W-1:0]          granted_block_size
);

    import bpa_pkg::*;

    localparam int NB   = (MAX_BLOCKS < COUNT_CAP) ? MAX_BLOCKS : COUNT_CAP;
    localparam int BIW  = $clog2(NB);
    localparam int PIW  = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int PW1  = $clog2(MAX_POOLS + 1);
    localparam int CMPW = (PW1 > SLOT_W) ? PW1 : SLOT_W;
    localparam int CW   = (NB < CHUNK_W) ? NB : CHUNK_W;
    localparam int NCH  = (NB + CW - 1) / CW;
    localparam int WW   = NCH * CW;
    localparam int CNW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int CIW  = $clog2(CW);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(NB);
    localparam logic [COUNT_W-1:0] COUNT_RESET =
        (COUNT_FALLBACK > COUNT_LIMIT) ? COUNT_LIMIT : COUNT_FALLBACK;

    logic [SIZE_W-1:0]   cfg_size_reg, cfg_size_next;
    logic [COUNT_W-1:0]  cfg_count_reg, cfg_count_next;
    logic [COUNT_W-1:0]  count_raw, count_fixed;
    logic [PW1-1:0]      pools_open_reg, pools_open_next;
    logic [PIW-1:0]      ptr_reg, ptr_next;

    logic [OP_W-1:0]     op_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [BLK_W-1:0]    blk_reg;

    logic [SIZE_W-1:0]   size_reg  [MAX_POOLS];
    logic [COUNT_W-1:0]  total_reg [MAX_POOLS];
    logic [COUNT_W-1:0]  free_reg  [MAX_POOLS];

    logic [WW-1:0]       word_reg;
    logic [NB-1:0]       row_reg;
    logic [CNW-1:0]      cnt_reg;
    logic [BIW-1:0]      found_reg;
    logic [CW-1:0]       chunk;
    logic [CIW-1:0]      idx;
    logic [BIW-1:0]      found;

    logic [NB-1:0]       ram_rdata, ram_wdata;
    logic                ram_we;
    logic [NB-1:0]       bit_found, bit_blk;
    logic [SIZE_W-1:0]   new_size;
    logic                slot_ok, blk_ok;

    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   gpool_reg;
    logic [BLK_W-1:0]    gblock_reg;
    logic [SIZE_W-1:0]   gsize_reg;
    logic                granted;

    // configuration registers
    always_comb
    begin
        cfg_size_next  = cfg_size_reg;
        cfg_count_next = cfg_count_reg;
        count_raw      = cfg_data[COUNT_W-1:0];
        count_fixed    = (count_raw == '0) ? COUNT_FALLBACK : count_raw;
        if (count_fixed > COUNT_LIMIT)
        begin
            count_fixed = COUNT_LIMIT;
        end
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DEFAULT_SIZE:
                begin
                    cfg_size_next = (cfg_data == '0) ? SIZE_FALLBACK : cfg_data;
                end
                REG_DEFAULT_COUNT:
                begin
                    cfg_count_next = count_fixed;
                end
                default:
                begin
                    cfg_size_next = cfg_size_reg;
                end
            endcase
        end
    end

    // pool pointer
    always_comb
    begin
        case (cmd.ptr_op)
            PTR_TOP:  ptr_next = PIW'(pools_open_reg - PW1'(1));
            PTR_DEC:  ptr_next = ptr_reg - PIW'(1);
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + PIW'(1);
            PTR_OPEN: ptr_next = PIW'(pools_open_reg);
            default:  ptr_next = ptr_reg;
        endcase
        if (cmd.capture)
        begin
            ptr_next = PIW'(pool_slot);
        end
    end

    assign pools_open_next = cmd.open_wr ? pools_open_reg + PW1'(1) : pools_open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_size_reg   <= SIZE_FALLBACK;
            cfg_count_reg  <= COUNT_RESET;
            pools_open_reg <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            cfg_size_reg   <= cfg_size_next;
            cfg_count_reg  <= cfg_count_next;
            pools_open_reg <= pools_open_next;
            ptr_reg        <= ptr_next;
        end
    end

    // lowest free block within the current chunk
    always_comb
    begin
        chunk = word_reg[CW-1:0];
        idx   = '0;
        for (int i = CW - 1; i >= 0; i--)
        begin
            if (!chunk[i])
            begin
                idx = CIW'(i);
            end
        end
        found = BIW'(int'(cnt_reg) * CW + int'(idx));
    end

    assign new_size  = (req_reg > cfg_size_reg) ? req_reg : cfg_size_reg;
    assign bit_found = NB'(1) << found_reg;
    assign bit_blk   = NB'(1) << blk_reg[BIW-1:0];
    assign slot_ok   = CMPW'(slot_reg) < CMPW'(pools_open_reg);
    assign blk_ok    = COUNT_W'(blk_reg) < total_reg[ptr_reg];

    // item fields, pool tables and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            req_reg  <= request_size;
            slot_reg <= pool_slot;
            blk_reg  <= free_block;
        end
        if (cmd.load_word)
        begin
            word_reg <= WW'(ram_rdata);
            row_reg  <= ram_rdata;
            cnt_reg  <= '0;
        end
        else if (cmd.shift_word)
        begin
            word_reg <= word_reg >> CW;
            cnt_reg  <= cnt_reg + CNW'(1);
        end
        if (cmd.search_hit)
        begin
            found_reg <= found;
        end
        else if (cmd.open_wr)
        begin
            found_reg <= '0;
        end
        if (cmd.grant_wr)
        begin
            free_reg[ptr_reg] <= free_reg[ptr_reg] - COUNT_W'(1);
        end
        if (cmd.open_wr)
        begin
            size_reg[ptr_reg]  <= new_size;
            total_reg[ptr_reg] <= cfg_count_reg;
            free_reg[ptr_reg]  <= cfg_count_reg - COUNT_W'(1);
        end
        if (cmd.free_wr)
        begin
            free_reg[ptr_reg] <= free_reg[ptr_reg] + COUNT_W'(1);
        end
        if (cmd.sweep_wr)
        begin
            free_reg[ptr_reg] <= total_reg[ptr_reg];
        end
    end

    // bitmap ram
    assign ram_we = cmd.grant_wr | cmd.open_wr | cmd.free_wr | cmd.sweep_wr;

    always_comb
    begin
        if (cmd.grant_wr)
        begin
            ram_wdata = row_reg | bit_found;
        end
        else if (cmd.open_wr)
        begin
            ram_wdata = NB'(1);
        end
        else if (cmd.free_wr)
        begin
            ram_wdata = ram_rdata & ~bit_blk;
        end
        else
        begin
            ram_wdata = '0;
        end
    end

    bpa_ram #(
        .WIDTH (NB),
        .DEPTH (MAX_POOLS)
    ) u_used_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // status to the controller
    always_comb
    begin
        sts.op          = op_reg;
        sts.pools_empty = (pools_open_reg == '0);
        sts.pools_full  = (pools_open_reg == PW1'(MAX_POOLS));
        sts.scan_hit    = (size_reg[ptr_reg] >= req_reg) && (free_reg[ptr_reg] != '0);
        sts.ptr_zero    = (ptr_reg == '0);
        sts.chunk_hit   = ~&chunk;
        sts.free_ok     = slot_ok && blk_ok && (|(ram_rdata & bit_blk));
        sts.sweep_last  = ((PW1'(ptr_reg) + PW1'(1)) == pools_open_reg);
    end

    // result register
    assign granted = (cmd.result == ST_EXISTING) || (cmd.result == ST_NEW);

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg <= cmd.result;
            gpool_reg  <= granted ? SLOT_W'(ptr_reg) : '0;
            gblock_reg <= granted ? BLK_W'(found_reg) : '0;
            gsize_reg  <= granted ? size_reg[ptr_reg] : '0;
        end
    end

    assign status             = status_reg;
    assign granted_pool       = gpool_reg;
    assign granted_block      = gblock_reg;
    assign granted_block_size = gsize_reg;

endmodule

// ===== design/block_pool_allocator.sv =====
// top level of the block pool allocator
`timescale 1ns / 1ps

// Fixed-size block pool allocator with a used-block bitmap per pool.
// Input channel (in_valid / in_stall) carries one item: op, request_size,
// pool_slot, free_block. Output channel (out_valid / out_stall) returns
// exactly one result item per input item: status and the granted fields.
// Configuration: cfg_we writes the default block size (index 0) or the
// default block count (index 1) from cfg_data; the user must write only while
// the block is idle, the block does not enforce it; other indexes are ignored.
// One item is worked on at a time; the next item is taken the cycle after its
// result is loaded into the output register, even while the receiver stalls
// it. A result still held by a stalled receiver delays loading the next one.
// Steps from accept to result valid:
//   free: bitmap row read, then the block check; reset op: sweep of open pools;
//   unused op: straight to the result; allocate: pool scan, bitmap ram read and
//   search of the 16-bit bitmap chunks (up to 8), or a new pool when none fits.
// The pool scan takes one pool per cycle, from the newest open pool down; with no
// free pool slot left, the result is the no-slot status.
// Reset clears all pools (none open) and loads the default registers;
// nothing waits on a clearing pass. A stalled result holds its fields.

module block_pool_allocator #(
    parameter int MAX_POOLS  = bpa_pkg::MAX_POOLS_DEF,
    parameter int MAX_BLOCKS = bpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bpa_pkg::OP_W-1:0]       op,
    input  logic [bpa_pkg::REQ_W-1:0]      request_size,
    input  logic [bpa_pkg::SLOT_W-1:0]     pool_slot,
    input  logic [bpa_pkg::BLK_W-1:0]      free_block,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bpa_pkg::STATUS_W-1:0]   status,
    output logic [bpa_pkg::SLOT_W-1:0]     granted_pool,
    output logic [bpa_pkg::BLK_W-1:0]      granted_block,
    output logic [bpa_pkg::SIZE_W-1:0]     granted_block_size
);

    import bpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    bpa_dpath #(
        .MAX_POOLS  (MAX_POOLS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .op                 (op),
        .request_size       (request_size),
        .pool_slot          (pool_slot),
        .free_block         (free_block),
        .cmd                (cmd),
        .sts                (sts),
        .status             (status),
        .granted_pool       (granted_pool),
        .granted_block      (granted_block),
        .granted_block_size (granted_block_size)
    );

endmodule

// ===== design/bpa_checker.sv =====
// port-level assertions for the block pool allocator and their bind
`timescale 1ns / 1ps

module bpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [bpa_pkg::STATUS_W-1:0]   status,
    input logic [bpa_pkg::SLOT_W-1:0]     granted_pool,
    input logic [bpa_pkg::BLK_W-1:0]      granted_block,
    input logic [bpa_pkg::SIZE_W-1:0]     granted_block_size
);

    import bpa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(granted_pool) && $stable(granted_block)
            && $stable(granted_block_size))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is in work");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_EXISTING) && (status != ST_NEW)
            |-> (granted_pool == '0) && (granted_block == '0)
                && (granted_block_size == '0))
        else $error("grant fields set on a non-grant result");

    a_grant_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_EXISTING) || (status == ST_NEW))
            |-> granted_block_size != '0)
        else $error("grant with zero block size");

    a_new_block0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NEW) |-> granted_block == '0)
        else $error("new pool did not hand out block 0");

endmodule

bind block_pool_allocator bpa_checker u_bpa_checker (.*);
